/* rtl/waveform_pedestal_peak_stats_top_defines.svh */
// Assertion macros for the pedestal / peak statistics block.
`ifndef WAVEFORM_PEDESTAL_PEAK_STATS_TOP_DEFINES_SVH
`define WAVEFORM_PEDESTAL_PEAK_STATS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define WPPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
`define WPPS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define WPPS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WPPS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/wpps_pkg.sv */
package wpps_pkg;

    localparam int MAX_SAMPLES = 1024;

    localparam int TIME_W = 32;
    localparam int SMP_W  = 16;
    localparam int AMP_W  = 17;
    localparam int PSMP_W = 11;
    localparam int CFG_W  = 32;
    localparam int CFG_IDX_W = 1;

    // sample counter holds MAX_SAMPLES itself
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SMP_W + CNT_W;

    localparam logic signed [SMP_W-1:0]  PEAK_START      = -16'sd1600;
    localparam logic signed [TIME_W-1:0] WIN_START_RESET = -32'sd1600;
    localparam logic signed [TIME_W-1:0] WIN_END_RESET   = 32'sd0;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_END   = 1'b1;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_PED_GO,
        ST_PED_RUN,
        ST_DIO_GO,
        ST_DIO_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [SUM_W-1:0] ped_sum;
        logic [CNT_W-1:0]        ped_cnt;
        logic signed [SMP_W-1:0] peak;
        logic signed [SUM_W-1:0] dio_sum;
        logic [CNT_W-1:0]        smp_cnt;
    } t_acc_stat;

endpackage

/* rtl/wpps_accum.sv */
module wpps_accum
    import wpps_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic                     i_clear,
    input  logic signed [TIME_W-1:0] i_win_start,
    input  logic signed [TIME_W-1:0] i_win_end,
    input  logic signed [TIME_W-1:0] i_sample_time,
    input  logic signed [SMP_W-1:0]  i_pulse_sample,
    input  logic signed [SMP_W-1:0]  i_diode_sample,
    output t_acc_stat                o_stat
);

    logic signed [SUM_W-1:0] r_ped_sum, n_ped_sum;
    logic [CNT_W-1:0]        r_ped_cnt, n_ped_cnt;
    logic signed [SMP_W-1:0] r_peak, n_peak;
    logic signed [SUM_W-1:0] r_dio_sum, n_dio_sum;
    logic [CNT_W-1:0]        r_smp_cnt, n_smp_cnt;

    logic in_win;
    logic upd;

    assign in_win = (i_sample_time >= i_win_start) && (i_sample_time <= i_win_end);
    // samples past the record limit are dropped
    assign upd    = i_accept && (r_smp_cnt < CNT_W'(MAX_SAMPLES));

    always_comb begin
        n_ped_sum = r_ped_sum;
        n_ped_cnt = r_ped_cnt;
        n_peak    = r_peak;
        n_dio_sum = r_dio_sum;
        n_smp_cnt = r_smp_cnt;
        if (i_clear) begin
            n_ped_sum = '0;
            n_ped_cnt = '0;
            n_peak    = PEAK_START;
            n_dio_sum = '0;
            n_smp_cnt = '0;
        end else if (upd) begin
            if (in_win) begin
                n_ped_sum = r_ped_sum + SUM_W'(i_pulse_sample);
                n_ped_cnt = r_ped_cnt + 1'b1;
            end
            if (i_pulse_sample > r_peak) begin
                n_peak = i_pulse_sample;
            end
            n_dio_sum = r_dio_sum + SUM_W'(i_diode_sample);
            n_smp_cnt = r_smp_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ped_sum <= '0;
            r_ped_cnt <= '0;
            r_peak    <= PEAK_START;
            r_dio_sum <= '0;
            r_smp_cnt <= '0;
        end else begin
            r_ped_sum <= n_ped_sum;
            r_ped_cnt <= n_ped_cnt;
            r_peak    <= n_peak;
            r_dio_sum <= n_dio_sum;
            r_smp_cnt <= n_smp_cnt;
        end
    end

    assign o_stat.ped_sum = r_ped_sum;
    assign o_stat.ped_cnt = r_ped_cnt;
    assign o_stat.peak    = r_peak;
    assign o_stat.dio_sum = r_dio_sum;
    assign o_stat.smp_cnt = r_smp_cnt;

endmodule

/* rtl/wpps_div.sv */
module wpps_div
    import wpps_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic signed [SUM_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(SUM_W);

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;

    logic [CNT_W:0]    rem_sh;
    logic              ge;
    logic [CNT_W:0]    rem_sub;

    // restoring division on magnitudes, one quotient bit a cycle
    assign rem_sh  = {r_rem, r_q[SUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_dividend[SUM_W-1];
            r_q    <= i_dividend[SUM_W-1] ? (SUM_W'(0) - i_dividend) : i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_step <= STEP_W'(SUM_W - 1);
        end else if (r_busy) begin
            r_rem  <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_q    <= {r_q[SUM_W-2:0], ge};
            r_step <= r_step - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? $signed(SUM_W'(0) - r_q) : $signed(r_q);

endmodule

/* rtl/waveform_pedestal_peak_stats_top.sv */
// channel  | handshake                 | beat
// ---------+---------------------------+---------------------------------------------
// input    | i_in_valid / o_in_ready   | time, pulse, diode, last
// output   | o_out_valid / i_out_ready | amplitude, diode mean, pedestal count, empty
// config   | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// Samples are taken one per cycle while a record accumulates.
// A beat with last set starts two passes of the shared bit-serial divider (SUM_W quotient
// bits each, 27 at MAX_SAMPLES = 1024), so the input stalls while the passes run: each
// pass has a start state and a run state, and a result state follows them.
// The result sits in an output register; the next record accumulates while it waits,
// but the next end of record holds until that register is free.
// Reset is synchronous, active low, clears the record state and sets the windows to their reset values.
`include "waveform_pedestal_peak_stats_top_defines.svh"

module waveform_pedestal_peak_stats_top
    import wpps_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [TIME_W-1:0] i_sample_time,
    input  logic signed [SMP_W-1:0]  i_pulse_sample,
    input  logic signed [SMP_W-1:0]  i_diode_sample,
    input  logic                     i_last,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [AMP_W-1:0]  o_amplitude,
    output logic signed [SMP_W-1:0]  o_diode_mean,
    output logic [PSMP_W-1:0]        o_pedestal_samples,
    output logic                     o_pedestal_empty
);

    t_state r_state, n_state;

    logic signed [TIME_W-1:0] r_win_start;
    logic signed [TIME_W-1:0] r_win_end;

    logic signed [SMP_W-1:0]  r_ped;
    logic signed [SMP_W-1:0]  r_dmean;

    logic                     r_out_valid;
    logic signed [AMP_W-1:0]  r_amp;
    logic signed [SMP_W-1:0]  r_dio_out;
    logic [PSMP_W-1:0]        r_psmp;
    logic                     r_empty;

    t_acc_stat                stat;
    logic                     accept;
    logic                     clear;
    logic                     load;
    logic                     div_start;
    logic                     div_done;
    logic signed [SUM_W-1:0]  div_num;
    logic [CNT_W-1:0]         div_den;
    logic signed [SUM_W-1:0]  div_quot;
    logic                     empty;
    logic signed [SMP_W-1:0]  ped_used;

    assign accept = i_in_valid && o_in_ready;
    assign empty  = (stat.ped_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start <= WIN_START_RESET;
            r_win_end   <= WIN_END_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIN_START: r_win_start <= $signed(i_cfg_data);
                CFG_WIN_END:   r_win_end   <= $signed(i_cfg_data);
                default:       ;
            endcase
        end
    end

    wpps_accum u_accum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_clear        (clear),
        .i_win_start    (r_win_start),
        .i_win_end      (r_win_end),
        .i_sample_time  (i_sample_time),
        .i_pulse_sample (i_pulse_sample),
        .i_diode_sample (i_diode_sample),
        .o_stat         (stat)
    );

    wpps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACC:     if (accept && i_last) n_state = ST_PED_GO;
            ST_PED_GO:  n_state = ST_PED_RUN;
            ST_PED_RUN: if (div_done) n_state = ST_DIO_GO;
            ST_DIO_GO:  n_state = ST_DIO_RUN;
            ST_DIO_RUN: if (div_done) n_state = ST_DONE;
            ST_DONE:    if (!r_out_valid || i_out_ready) n_state = ST_ACC;
            default:    n_state = ST_ACC;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        div_start  = 1'b0;
        div_num    = stat.dio_sum;
        div_den    = stat.smp_cnt;
        load       = 1'b0;
        unique case (r_state)
            ST_ACC:     o_in_ready = 1'b1;
            ST_PED_GO: begin
                div_start = 1'b1;
                div_num   = stat.ped_sum;
                div_den   = stat.ped_cnt;
            end
            ST_PED_RUN: ;
            ST_DIO_GO:  div_start = 1'b1;
            ST_DIO_RUN: ;
            ST_DONE:    load = !r_out_valid || i_out_ready;
            default:    ;
        endcase
    end

    assign clear = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PED_RUN && div_done) begin
            r_ped <= div_quot[SMP_W-1:0];
        end
        if (r_state == ST_DIO_RUN && div_done) begin
            // no samples at all gives a mean of zero
            r_dmean <= (stat.smp_cnt == '0) ? '0 : div_quot[SMP_W-1:0];
        end
    end

    assign ped_used = empty ? '0 : r_ped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_amp     <= AMP_W'(stat.peak) - AMP_W'(ped_used);
            r_dio_out <= r_dmean;
            r_psmp    <= PSMP_W'(stat.ped_cnt);
            r_empty   <= empty;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_amplitude        = r_amp;
    assign o_diode_mean       = r_dio_out;
    assign o_pedestal_samples = r_psmp;
    assign o_pedestal_empty   = r_empty;

    `WPPS_ASSERT_IMP(a_div_done_in_run, i_clk, !i_rst_n, div_done, (r_state == ST_PED_RUN || r_state == ST_DIO_RUN))
    `WPPS_ASSERT_NXT(a_done_holds_blocked, i_clk, !i_rst_n, (r_state == ST_DONE && r_out_valid && !i_out_ready), (r_state == ST_DONE))
    `WPPS_ASSERT_NXT(a_load_sets_valid, i_clk, !i_rst_n, load, (r_out_valid && r_state == ST_ACC && stat.smp_cnt == '0))
    `WPPS_ASSERT_IMP(a_no_accept_busy, i_clk, !i_rst_n, (r_state != ST_ACC), !accept)

endmodule

/* test/tb_waveform_pedestal_peak_stats_top.sv */
module tb_waveform_pedestal_peak_stats_top;
    import wpps_pkg::*;

    localparam int     RND_ITEMS = 2000;
    localparam int     PHASE_ITEMS = 300;
    localparam int     LIMIT = 1000000;
    localparam int     DRAIN_CYC = 2 * SUM_W + 16;
    localparam int     LONG_HOLD = 400;
    localparam longint T_MAX = 64'sd2147483647;
    localparam longint T_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [TIME_W-1:0] t;
        logic signed [SMP_W-1:0]  pulse;
        logic signed [SMP_W-1:0]  diode;
        logic                     last;
    } sample_t;

    typedef struct packed {
        logic signed [AMP_W-1:0] amp;
        logic signed [SMP_W-1:0] dmean;
        logic [PSMP_W-1:0]       ped_n;
        logic                    empty;
    } stats_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx = CFG_WIN_START;
    logic [CFG_W-1:0]         i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic signed [TIME_W-1:0] i_sample_time = '0;
    logic signed [SMP_W-1:0]  i_pulse_sample = '0;
    logic signed [SMP_W-1:0]  i_diode_sample = '0;
    logic                     i_last = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [AMP_W-1:0]  o_amplitude;
    logic signed [SMP_W-1:0]  o_diode_mean;
    logic [PSMP_W-1:0]        o_pedestal_samples;
    logic                     o_pedestal_empty;

    waveform_pedestal_peak_stats_top i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_sample_time      (i_sample_time),
        .i_pulse_sample     (i_pulse_sample),
        .i_diode_sample     (i_diode_sample),
        .i_last             (i_last),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_amplitude        (o_amplitude),
        .o_diode_mean       (o_diode_mean),
        .o_pedestal_samples (o_pedestal_samples),
        .o_pedestal_empty   (o_pedestal_empty)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // window registers as the block should hold them
    logic signed [TIME_W-1:0] win_lo = WIN_START_RESET;
    logic signed [TIME_W-1:0] win_hi = WIN_END_RESET;

    // running record statistics
    logic signed [SUM_W-1:0] rec_ped_sum = '0;
    logic [CNT_W-1:0]        rec_ped_cnt = '0;
    logic signed [SMP_W-1:0] rec_peak = PEAK_START;
    logic signed [SUM_W-1:0] rec_dio_sum = '0;
    logic [CNT_W-1:0]        rec_smp_cnt = '0;

    sample_t sample_feed_q[$];
    stats_t  stats_due_q[$];
    sample_t cur_beat;

    int  pushed_n = 0;
    int  taken_n = 0;
    int  res_n = 0;
    int  errors = 0;
    int  cyc_n = 0;
    int  idle_pct = 0;
    int  stall_pct = 0;
    int  in_gap = 0;
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;
    logic in_taken = 1'b0;

    function automatic logic signed [TIME_W-1:0] clamp_t(input longint v);
        if (v > T_MAX) return TIME_W'(T_MAX);
        if (v < T_MIN) return TIME_W'(T_MIN);
        return TIME_W'(v);
    endfunction

    // folds one sample into the record; returns 1 with the stats at end of record
    function automatic bit accumulate_sample(input sample_t s, output stats_t r);
        longint ped;
        longint dmean;
        longint amp;
        ped = 0;
        dmean = 0;
        r = '0;
        if (rec_smp_cnt < MAX_SAMPLES) begin
            if (s.t >= win_lo && s.t <= win_hi) begin
                rec_ped_sum += s.pulse;
                rec_ped_cnt++;
            end
            if (s.pulse > rec_peak) rec_peak = s.pulse;
            rec_dio_sum += s.diode;
            rec_smp_cnt++;
        end
        if (!s.last) return 1'b0;
        if (rec_ped_cnt != 0) ped = longint'(rec_ped_sum) / longint'(rec_ped_cnt);
        if (rec_smp_cnt != 0) dmean = longint'(rec_dio_sum) / longint'(rec_smp_cnt);
        amp = longint'(rec_peak) - ped;
        r.amp = AMP_W'(amp);
        r.dmean = SMP_W'(dmean);
        r.ped_n = PSMP_W'(rec_ped_cnt);
        r.empty = (rec_ped_cnt == 0);
        rec_ped_sum = '0;
        rec_ped_cnt = '0;
        rec_peak = PEAK_START;
        rec_dio_sum = '0;
        rec_smp_cnt = '0;
        return 1'b1;
    endfunction

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // beat still waiting
        end else if (in_gap != 0) begin
            in_gap--;
            i_in_valid <= 1'b0;
        end else if (sample_feed_q.size() != 0 && idle_pct != 0 &&
                     $urandom_range(0, 99) < idle_pct) begin
            in_gap = $urandom_range(0, 9);
            i_in_valid <= 1'b0;
        end else if (sample_feed_q.size() != 0) begin
            cur_beat = sample_feed_q.pop_front();
            i_sample_time <= cur_beat.t;
            i_pulse_sample <= cur_beat.pulse;
            i_diode_sample <= cur_beat.diode;
            i_last <= cur_beat.last;
            i_in_valid <= 1'b1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // receiver, with one long hold-off once results are flowing
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!long_hold_done && res_n >= 40) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            hold_left = $urandom_range(0, 9);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // checker: compare finished records first, then fold in the accepted sample
    always @(posedge i_clk) begin
        stats_t  got;
        stats_t  want;
        stats_t  pred;
        sample_t s;
        cyc_n++;
        if (cyc_n > LIMIT) begin
            $display("tb_waveform_pedestal_peak_stats_top: errors");
            $finish;
        end else begin
            in_taken <= i_rst_n && i_in_valid && o_in_ready;
            if (i_rst_n && o_out_valid && i_out_ready) begin
                res_n++;
                got.amp = o_amplitude;
                got.dmean = o_diode_mean;
                got.ped_n = o_pedestal_samples;
                got.empty = o_pedestal_empty;
                if (stats_due_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected beat: amp %0d dmean %0d ped_n %0d empty %0b",
                                 got.amp, got.dmean, got.ped_n, got.empty);
                end else begin
                    want = stats_due_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch (exp/act): amp %0d/%0d dmean %0d/%0d ",
                                      "ped_n %0d/%0d empty %0b/%0b"},
                                     want.amp, got.amp, want.dmean, got.dmean,
                                     want.ped_n, got.ped_n, want.empty, got.empty);
                    end
                end
            end
            if (i_rst_n && i_in_valid && o_in_ready) begin
                taken_n++;
                s.t = i_sample_time;
                s.pulse = i_pulse_sample;
                s.diode = i_diode_sample;
                s.last = i_last;
                if (accumulate_sample(s, pred)) stats_due_q.push_back(pred);
            end
        end
    end

    task automatic put(input logic signed [TIME_W-1:0] t, input int p, input int d,
                       input bit l);
        sample_t s;
        s.t = t;
        s.pulse = SMP_W'(p);
        s.diode = SMP_W'(d);
        s.last = l;
        sample_feed_q.push_back(s);
        pushed_n++;
    endtask

    // wait until every sample is taken and every record reported, then let the divider settle
    task automatic drain();
        while (taken_n != pushed_n || stats_due_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic set_window(input longint lo, input longint hi);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_WIN_START;
        i_cfg_data <= clamp_t(lo);
        win_lo = clamp_t(lo);
        @(negedge i_clk);
        i_cfg_idx <= CFG_WIN_END;
        i_cfg_data <= clamp_t(hi);
        win_hi = clamp_t(hi);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one record: times mostly ramp through the window, otherwise random or on its edges
    task automatic queue_record(input int len);
        int     tmode;
        int     pmode;
        int     dmode;
        int     p;
        int     d;
        longint step;
        longint t0;
        logic signed [TIME_W-1:0] t;
        tmode = $urandom_range(0, 9);
        pmode = $urandom_range(0, 3);
        dmode = $urandom_range(0, 3);
        step = $urandom_range(1, 64);
        t0 = longint'(win_lo) - longint'($urandom_range(0, 12)) * step;
        for (int k = 0; k < len; k++) begin
            if (tmode < 7) t = clamp_t(t0 + k * step);
            else if (tmode < 9) t = $urandom;
            else t = ($urandom_range(0, 1) != 0) ? win_lo : win_hi;
            if (pmode == 0) p = int'(PEAK_START) - 100 + int'($urandom_range(0, 200));
            else if (pmode == 1) p = int'($urandom_range(0, 400)) - 200;
            else p = $urandom;
            if (dmode == 0) d = int'($urandom_range(0, 400)) - 200;
            else d = $urandom;
            put(t, p, d, k == len - 1);
        end
    endtask

    initial begin
        int     rnd_n;
        int     ph_n;
        int     len;
        longint lo;
        longint hi;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 20;
        stall_pct = 20;

        // default window: edges, field extremes, equal peak
        put(32'sh8000_0000, -32768, -32768, 1'b0);
        put(-1600, -32768, 32767, 1'b0);
        put(0, 100, 32767, 1'b0);
        put(1, 32767, -1, 1'b0);
        put(32'sh7fff_ffff, 32767, 0, 1'b1);
        // nothing in window, peak never above -100 mV
        put(16000, -1601, 5, 1'b0);
        put(-1601, -1600, -7, 1'b1);
        // single-sample record
        put(-800, -5, -3, 1'b1);
        // negative sums truncate toward zero
        put(-16, -3, -3, 1'b0);
        put(-32, -2, 4, 1'b1);
        drain();

        // start after end: always empty
        set_window(100, -100);
        put(0, 50, 10, 1'b0);
        put(100, -32768, 11, 1'b0);
        put(-100, 7, 12, 1'b1);
        drain();

        // full range window
        set_window(T_MIN, T_MAX);
        put(32'sh8000_0000, -32768, -32768, 1'b0);
        put(32'sh7fff_ffff, -32768, -32768, 1'b1);
        put(5, 32767, 32767, 1'b0);
        put(6, 32767, 32767, 1'b1);
        drain();

        set_window(T_MAX, T_MAX);
        put(32'sh7fff_ffff, 9, 1, 1'b0);
        put(32'sh7fff_fffe, 20, 2, 1'b1);
        drain();

        set_window(T_MIN, T_MIN);
        put(32'sh8000_0000, -9, 3, 1'b0);
        put(32'sh8000_0001, -1601, 4, 1'b1);
        drain();

        rnd_n = 0;
        for (int ph = 0; rnd_n < RND_ITEMS; ph++) begin
            if (rnd_n > RND_ITEMS - 350) begin
                idle_pct = 0;
                stall_pct = 0;
            end else begin
                idle_pct = 20 * $urandom_range(0, 2);
                stall_pct = 20 * $urandom_range(0, 2);
            end
            case (ph % 6)
                0: begin
                    lo = WIN_START_RESET;
                    hi = WIN_END_RESET;
                end
                1: begin
                    lo = -longint'($urandom_range(0, 4000));
                    hi = lo + $urandom_range(0, 4000);
                end
                2: begin
                    lo = $signed($urandom);
                    hi = lo + $urandom_range(0, 3000);
                end
                3: begin
                    lo = T_MIN;
                    hi = T_MAX;
                end
                4: begin
                    lo = $urandom_range(1, 5000);
                    hi = lo - $urandom_range(1, 5000);
                end
                default: begin
                    lo = -longint'($urandom_range(0, 2000));
                    hi = lo;
                end
            endcase
            set_window(lo, hi);
            ph_n = 0;
            while (ph_n < PHASE_ITEMS) begin
                // overlong record: samples past MAX_SAMPLES are dropped by the block
                if (ph == 1 && ph_n == 0)
                    len = $urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 40);
                else
                    len = $urandom_range(1, 24);
                queue_record(len);
                ph_n += (len > MAX_SAMPLES) ? MAX_SAMPLES : len;
            end
            rnd_n += ph_n;
            drain();
        end

        if (errors == 0) begin
            $display("tb_waveform_pedestal_peak_stats_top: clean");
        end else begin
            $display("tb_waveform_pedestal_peak_stats_top: errors");
        end
        $finish;
    end

endmodule
